### src/csv_pkg.sv
package csv_pkg;

  localparam int unsigned CSV_ADDR_W = 3;
  localparam int unsigned CSV_DATA_W = 32;
  localparam logic [7:0]  CSV_SEP_RESET = 8'h00;

  typedef enum logic [1:0] {
    END_SEP   = 2'd0,
    END_LINE  = 2'd1,
    END_TEXT  = 2'd2,
    END_OPENQ = 2'd3
  } end_kind_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       field_end;
    end_kind_e  end_kind;
  } csv_res_t;

endpackage

### src/csv_cfg.sv
module csv_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csv_pkg::CSV_ADDR_W-1:0]  paddr,
  input  logic [csv_pkg::CSV_DATA_W-1:0]  pwdata,
  output logic [csv_pkg::CSV_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [7:0]                      sep_o
);
  import csv_pkg::*;

  logic [7:0] sep_q;
  logic       sel_sep;

  assign pready  = 1'b1;
  assign sel_sep = (paddr[CSV_ADDR_W-1] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= CSV_SEP_RESET;
    end else if (psel && penable && pwrite && pready && sel_sep) begin
      sep_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_sep) begin
      prdata = {{(CSV_DATA_W-8){1'b0}}, sep_q};
    end
  end

  assign sep_o = sep_q;

endmodule

### src/csv_parse.sv
module csv_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        sep_i,
  input  logic              room_i,
  output logic              push_o,
  output csv_pkg::csv_res_t res_o
);
  import csv_pkg::*;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_AFTER_CR = 3'd1,
    MODE_PLAIN    = 3'd2,
    MODE_QUOTED   = 3'd3,
    MODE_QSEEN    = 3'd4,
    MODE_SKIP     = 3'd5
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       vld_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       res_vld;
  csv_res_t   res;

  logic       is_sep, is_nul, is_quote, is_cr, is_lf;
  logic       plain_end;
  end_kind_e  plain_kind;
  mode_e      plain_next;

  assign is_nul   = (byte_q == CHR_NUL);
  assign is_quote = (byte_q == CHR_QUOTE);
  assign is_cr    = (byte_q == CHR_CR);
  assign is_lf    = (byte_q == CHR_LF);
  assign is_sep   = (sep_i != CHR_NUL) ? (byte_q == sep_i) :
                    ((byte_q == CHR_SEMI) || (byte_q == CHR_COMMA) || (byte_q == CHR_TAB));

  always_comb begin
    plain_end  = 1'b1;
    plain_kind = END_SEP;
    plain_next = MODE_START;
    if (is_sep) begin
      plain_kind = END_SEP;
    end else if (is_cr) begin
      plain_kind = END_LINE;
      plain_next = MODE_AFTER_CR;
    end else if (is_lf) begin
      plain_kind = END_LINE;
    end else begin
      plain_end = 1'b0;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    res_vld = 1'b0;
    res     = '{out_char: 8'h00, has_char: 1'b0, field_end: 1'b0, end_kind: END_SEP};
    unique case (mode_q)
      MODE_PLAIN: begin
        if (is_nul) begin
          mode_d  = MODE_START;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = END_TEXT;
        end else if (plain_end) begin
          mode_d  = plain_next;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = plain_kind;
        end else begin
          res_vld = 1'b1;
          res.out_char = byte_q;
          res.has_char = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (is_nul) begin
          mode_d  = MODE_START;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = END_OPENQ;
        end else if (is_quote) begin
          mode_d = MODE_QSEEN;
        end else begin
          res_vld = 1'b1;
          res.out_char = byte_q;
          res.has_char = 1'b1;
        end
      end
      MODE_QSEEN, MODE_SKIP: begin
        if (mode_q == MODE_QSEEN && is_quote) begin
          mode_d  = MODE_QUOTED;
          res_vld = 1'b1;
          res.out_char = byte_q;
          res.has_char = 1'b1;
        end else if (is_nul) begin
          mode_d  = MODE_START;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = END_TEXT;
        end else if (plain_end) begin
          mode_d  = plain_next;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = plain_kind;
        end else begin
          mode_d = MODE_SKIP;
        end
      end
      default: begin
        if (mode_q == MODE_AFTER_CR && is_lf) begin
          mode_d = MODE_START;
        end else if (is_nul) begin
          mode_d = MODE_START;
        end else if (is_quote) begin
          mode_d = MODE_QUOTED;
        end else if (plain_end) begin
          mode_d  = plain_next;
          res_vld = 1'b1;
          res.field_end = 1'b1;
          res.end_kind  = plain_kind;
        end else begin
          mode_d  = MODE_PLAIN;
          res_vld = 1'b1;
          res.out_char = byte_q;
          res.has_char = 1'b1;
        end
      end
    endcase
  end

  assign advance    = vld_q && (!res_vld || room_i);
  assign in_ready_o = !vld_q || advance;
  assign push_o     = advance && res_vld;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      mode_q <= MODE_START;
    end else begin
      if (in_valid_i && in_ready_o) begin
        vld_q <= 1'b1;
      end else if (advance) begin
        vld_q <= 1'b0;
      end
      if (advance) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

### src/csv_outq.sv
module csv_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csv_pkg::csv_res_t res_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csv_pkg::csv_res_t res_o
);
  import csv_pkg::*;

  csv_res_t   mem_q [2];
  logic [1:0] cnt_q;
  logic       wr_q, rd_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign room_o      = (cnt_q != 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign res_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

### src/csv_field_splitter.sv
// CSV field splitter, one text byte per transfer.
// Input channel: in_byte_i with in_valid_i / in_ready_o; a byte of 0 ends
// the text. Output channel: out_char_o, has_char_o, field_end_o, end_kind_o
// with out_valid_o / out_ready_i; each byte gives at most one result, either
// a decoded character or a field-end marker carrying the end reason.
// Configuration: APB write of the separator byte at address 0; 0 selects
// semicolon, comma and tab together.
// Throughput: one byte per clock, sustained, while the receiver takes results.
// Path: a byte transferred in is held in the input register; the parse step
// reads it and writes its result into the two-entry output queue, which
// offers it on the output channel.
// Reset clears the parse state to field start, the separator to 0 and
// empties both stages. When the receiver stalls, the output queue holds up
// to two results and the input register one byte; in_ready_o then drops
// until results drain, and nothing is lost.
module csv_field_splitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      in_byte_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output logic [7:0]                      out_char_o,
  output logic                            has_char_o,
  output logic                            field_end_o,
  output logic [1:0]                      end_kind_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csv_pkg::CSV_ADDR_W-1:0]  paddr,
  input  logic [csv_pkg::CSV_DATA_W-1:0]  pwdata,
  output logic [csv_pkg::CSV_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import csv_pkg::*;

  logic [7:0] sep;
  logic       room;
  logic       push;
  csv_res_t   res_in;
  csv_res_t   res_out;

  csv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sep_o   (sep)
  );

  csv_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sep_i      (sep),
    .room_i     (room),
    .push_o     (push),
    .res_o      (res_in)
  );

  csv_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_in),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign out_char_o  = res_out.out_char;
  assign has_char_o  = res_out.has_char;
  assign field_end_o = res_out.field_end;
  assign end_kind_o  = res_out.end_kind;

endmodule

### src/csv_chk.sv
module csv_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] out_char_o,
  input logic       has_char_o,
  input logic       field_end_o,
  input logic [1:0] end_kind_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);
  import csv_pkg::*;

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_char_o != field_end_o))
    else $error("result is neither a single character nor a single field end");

  a_char_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_char_o) |-> (end_kind_o == END_SEP))
    else $error("character result carries an end reason");

  a_end_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && field_end_o) |-> (out_char_o == 8'h00))
    else $error("field-end result carries a character");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(in_valid_i && in_ready_o) && !$past(out_valid_o, 1) && !$past(out_valid_o, 2)
     && !$past(in_valid_i && in_ready_o, 2)) |-> !out_valid_o)
    else $error("result offered without a byte transferred in");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_char_o)
                                       && $stable(end_kind_o)))
    else $error("stalled result changed");

endmodule

bind csv_field_splitter csv_chk u_csv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_char_o  (out_char_o),
  .has_char_o  (has_char_o),
  .field_end_o (field_end_o),
  .end_kind_o  (end_kind_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import csv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CSV_ADDR_W-1:0] REG_SEP = '0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef enum logic [2:0] {
    PM_START,
    PM_AFTER_CR,
    PM_PLAIN,
    PM_QUOTED,
    PM_QSEEN,
    PM_SKIP
  } split_mode_e;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_THIRD
  } rx_pattern_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic [7:0]            in_byte_i = 8'h00;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            out_char_o;
  logic                  has_char_o;
  logic                  field_end_o;
  logic [1:0]            end_kind_o;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CSV_ADDR_W-1:0] paddr;
  logic [CSV_DATA_W-1:0] pwdata;
  logic [CSV_DATA_W-1:0] prdata;
  logic                  pready;

  split_mode_e split_mode;
  logic [7:0]  sep_cfg;
  logic [7:0]  text_q [$];
  csv_res_t    fields_q [$];
  csv_res_t    drv_res;
  csv_res_t    mon_got;
  csv_res_t    mon_want;

  int          n_queued;
  int          n_in;
  int          n_rx;
  int          n_err;
  int          n_chars;
  int          n_kind [4];
  int          n_cfg;
  int          n_cyc;
  int          burst_left;
  int          gap_left;
  int          hold_cnt;
  int          mode_left;
  int          rx_tick;
  bit          held_long;
  bit          rdy;
  rx_pattern_e rx_mode;

  csv_field_splitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_char_o  (out_char_o),
    .has_char_o  (has_char_o),
    .field_end_o (field_end_o),
    .end_kind_o  (end_kind_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_sep(input logic [7:0] c);
    if (sep_cfg != CH_NUL) begin
      return c == sep_cfg;
    end
    return c == CH_SEMI || c == CH_COMMA || c == CH_TAB;
  endfunction

  function automatic csv_res_t char_res(input logic [7:0] c);
    csv_res_t r;
    r = '0;
    r.out_char = c;
    r.has_char = 1'b1;
    return r;
  endfunction

  function automatic csv_res_t end_res(input end_kind_e k);
    csv_res_t r;
    r = '0;
    r.field_end = 1'b1;
    r.end_kind = k;
    return r;
  endfunction

  function automatic bit outside_byte(input logic [7:0] c, input bit drop,
                                      output csv_res_t r);
    r = '0;
    if (is_sep(c)) begin
      split_mode = PM_START;
      r = end_res(END_SEP);
      return 1'b1;
    end
    if (c == CH_CR) begin
      split_mode = PM_AFTER_CR;
      r = end_res(END_LINE);
      return 1'b1;
    end
    if (c == CH_LF) begin
      split_mode = PM_START;
      r = end_res(END_LINE);
      return 1'b1;
    end
    if (drop) begin
      split_mode = PM_SKIP;
      return 1'b0;
    end
    split_mode = PM_PLAIN;
    r = char_res(c);
    return 1'b1;
  endfunction

  function automatic bit split_step(input logic [7:0] c, output csv_res_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    case (split_mode)
      PM_PLAIN: begin
        if (c == CH_NUL) begin
          split_mode = PM_START;
          r = end_res(END_TEXT);
          hit = 1'b1;
        end else begin
          hit = outside_byte(c, 1'b0, r);
        end
      end
      PM_QUOTED: begin
        if (c == CH_NUL) begin
          split_mode = PM_START;
          r = end_res(END_OPENQ);
          hit = 1'b1;
        end else if (c == CH_QUOTE) begin
          split_mode = PM_QSEEN;
        end else begin
          r = char_res(c);
          hit = 1'b1;
        end
      end
      PM_QSEEN: begin
        if (c == CH_QUOTE) begin
          split_mode = PM_QUOTED;
          r = char_res(c);
          hit = 1'b1;
        end else if (c == CH_NUL) begin
          split_mode = PM_START;
          r = end_res(END_TEXT);
          hit = 1'b1;
        end else begin
          hit = outside_byte(c, 1'b1, r);
        end
      end
      PM_SKIP: begin
        if (c == CH_NUL) begin
          split_mode = PM_START;
          r = end_res(END_TEXT);
          hit = 1'b1;
        end else begin
          hit = outside_byte(c, 1'b1, r);
        end
      end
      default: begin
        if (split_mode == PM_AFTER_CR && c == CH_LF) begin
          split_mode = PM_START;
        end else if (c == CH_NUL) begin
          split_mode = PM_START;
        end else if (c == CH_QUOTE) begin
          split_mode = PM_QUOTED;
        end else begin
          hit = outside_byte(c, 1'b0, r);
        end
      end
    endcase
    return hit;
  endfunction

  function automatic void put(input logic [7:0] b);
    text_q.push_back(b);
    n_queued++;
  endfunction

  function automatic void put_str(input string s);
    foreach (s[i]) put(s[i]);
  endfunction

  function automatic logic [7:0] pick_plain(input bit first);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (is_sep(b) || b == CH_CR || b == CH_LF || (first && b == CH_QUOTE));
    return b;
  endfunction

  function automatic logic [7:0] pick_quoted();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_sep();
    if (sep_cfg != CH_NUL) begin
      return sep_cfg;
    end
    case ($urandom_range(0, 2))
      0: return CH_SEMI;
      1: return CH_COMMA;
      default: return CH_TAB;
    endcase
  endfunction

  // Mostly well-formed records with random content, some raw noise.
  task automatic gen_text(input int n);
    int stop_at;
    int len;
    int kind;
    int term;
    stop_at = n_queued + n;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) put(8'($urandom_range(0, 255)));
        continue;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) put(pick_plain(i == 0));
      end else if (kind <= 8) begin
        put(CH_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) begin
            put(CH_QUOTE);
            put(CH_QUOTE);
          end else begin
            put(pick_quoted());
          end
        end
        if ($urandom_range(0, 14) == 0) begin
          put(CH_NUL);
          continue;
        end
        put(CH_QUOTE);
        if (kind == 8) begin
          repeat ($urandom_range(1, 3)) put(pick_plain(1'b0));
        end
      end
      term = $urandom_range(0, 9);
      if (term <= 4) begin
        put(pick_sep());
      end else if (term == 5) begin
        put(CH_CR);
      end else if (term == 6) begin
        put(CH_LF);
      end else if (term == 7) begin
        put(CH_CR);
        put(CH_LF);
      end else begin
        put(CH_NUL);
      end
    end
  endtask

  task automatic wait_idle(input int settle);
    while (text_q.size() != 0 || in_valid_i || fields_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_sep(input logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SEP;
    pwdata <= {{(CSV_DATA_W-8){1'b0}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== v) begin
      if (n_err < 10) $display("tb: separator read back %02h, wrote %02h", prdata[7:0], v);
      n_err++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    sep_cfg = v;
    n_cfg++;
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (split_step(in_byte_i, drv_res)) fields_q.push_back(drv_res);
        n_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_byte_i <= text_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: check each transfer, then pick readiness for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        mon_got = {out_char_o, has_char_o, field_end_o, end_kind_o};
        if (fields_q.size() == 0) begin
          if (n_err < 10) begin
            $display("tb: unexpected result %0d: char %02h has %0b end %0b kind %0d",
                     n_rx, mon_got.out_char, mon_got.has_char, mon_got.field_end,
                     mon_got.end_kind);
          end
          n_err++;
        end else begin
          mon_want = fields_q.pop_front();
          if (mon_got.out_char !== mon_want.out_char ||
              mon_got.has_char !== mon_want.has_char ||
              mon_got.field_end !== mon_want.field_end ||
              mon_got.end_kind !== mon_want.end_kind) begin
            if (n_err < 10) begin
              $display("tb: result %0d want %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                       n_rx, mon_want.out_char, mon_want.has_char, mon_want.field_end,
                       mon_want.end_kind, mon_got.out_char, mon_got.has_char,
                       mon_got.field_end, mon_got.end_kind);
            end
            n_err++;
          end
          if (mon_want.field_end) n_kind[mon_want.end_kind]++;
          else n_chars++;
        end
        n_rx++;
      end
      if (hold_cnt == 0 &&
          ((!held_long && n_rx >= 40 && in_valid_i) || $urandom_range(0, 599) == 0)) begin
        hold_cnt = $urandom_range(40, 80);
        held_long = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode = rx_pattern_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 150);
      end else begin
        mode_left--;
      end
      rx_tick++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   rdy = 1'b1;
          RX_RANDOM: rdy = ($urandom_range(0, 9) < 6);
          default:   rdy = (rx_tick % 3 == 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    n_cyc++;
    if (n_cyc >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending", n_cyc, fields_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] sep_list [6];
    int         len_list [6];
    sep_list = '{CH_COMMA, 8'hFF, CH_QUOTE, CH_CR, CH_PIPE, CH_NUL};
    len_list = '{100, 80, 60, 60, 80, 70};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    split_mode = PM_START;
    sep_cfg = CSV_SEP_RESET;
    burst_left = 1;
    gap_left = 0;
    hold_cnt = 0;
    mode_left = 0;
    rx_mode = RX_FREE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_str("a\"b;");
    put(CH_NUL);
    put_str("\"x\"\"y\"z");
    put(CH_TAB);
    put(8'hFF);
    put(CH_COMMA);
    put(CH_CR);
    put(CH_LF);
    put_str("\"o");
    put(CH_NUL);
    put(CH_NUL);
    put_str("\"a\"");
    put(CH_NUL);
    put_str("m");
    put(CH_CR);
    put(CH_NUL);
    gen_text(150);
    wait_idle(4);

    foreach (sep_list[i]) begin
      write_sep(sep_list[i]);
      gen_text(len_list[i]);
      wait_idle(4);
    end

    wait_idle(8);
    if (fields_q.size() != 0) begin
      $display("tb: %0d expected results never arrived", fields_q.size());
      n_err += fields_q.size();
    end
    $display("tb: %0d bytes in, %0d results: %0d chars", n_in, n_rx, n_chars);
    $display("tb: ends sep/line/text/open %0d/%0d/%0d/%0d",
             n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    $display("tb: %0d separator writes incl. 0x00 and 0xff, long output hold-off %0s",
             n_cfg, held_long ? "seen" : "missed");
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/csv_pkg.sv
src/csv_cfg.sv
src/csv_parse.sv
src/csv_outq.sv
src/csv_field_splitter.sv
src/csv_chk.sv
tb/tb.sv
